### hw/rtl/float_constant_recognizer_unit_assert.svh
// Assertion macros for the checker file of the float constant recognizer.
// Needs clk and rst_n in the scope that uses them.
`ifndef FLOAT_CONSTANT_RECOGNIZER_UNIT_ASSERT_SVH
`define FLOAT_CONSTANT_RECOGNIZER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define FCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define FCR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset too.
`define FCR_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fcr_pkg.sv
// Shared types and constants of the float constant recognizer.
// No dependencies.
package fcr_pkg;

  typedef enum logic [7:0] {
    PH_START   = 8'b0000_0001,
    PH_INT     = 8'b0000_0010,
    PH_FRAC    = 8'b0000_0100,
    PH_EXP     = 8'b0000_1000,
    PH_EXPSIGN = 8'b0001_0000,
    PH_EXPDIG  = 8'b0010_0000,
    PH_SUFFIX  = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    V_CONT  = 2'd0,
    V_MATCH = 2'd1,
    V_ERROR = 2'd2
  } verdict_t;

  localparam int MANT_W = 5;
  localparam int EXP_W  = 3;

  typedef struct packed {
    phase_t            phase;
    logic [MANT_W-1:0] mcount;
    logic [EXP_W-1:0]  ecount;
  } parse_st_t;

  localparam logic [1:0] REG_MAX_MANT = 2'd0;
  localparam logic [1:0] REG_MAX_EXP  = 2'd1;

  localparam logic [MANT_W-1:0] MAX_MANT_RST = 5'd16;
  localparam logic [EXP_W-1:0]  MAX_EXP_RST  = 3'd3;

  localparam parse_st_t PARSE_ST_RST = '{phase: PH_START, mcount: '0, ecount: '0};

endpackage

### hw/rtl/float_constant_recognizer_unit.sv
// Float constant recognizer: an input stage register and a result stage register lie between input
// request and result request; throughput one character per cycle, stalls only on out_tready low.
// rst_n is synchronous, active low: clears both pipeline valids, returns the parser
// to the start phase and reloads the limits (16 mantissa, 3 exponent digits).
// The parse state register closes a loop through the combinational fcr_step.
// Depends on fcr_pkg and fcr_step.
module float_constant_recognizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tuser,   // [0] first_char
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] verdict, [7:2] zero
  // register writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);
  import fcr_pkg::*;

  // limit registers
  logic [MANT_W-1:0] max_mant_r;
  logic [EXP_W-1:0]  max_exp_r;

  // input stage
  logic       s1_v_r;
  logic [7:0] s1_char_r;
  logic       s1_first_r;

  // result stage
  logic     out_v_r;
  verdict_t out_verdict_r;

  // parser state, updated when the input stage moves to the result stage
  parse_st_t st_r;
  parse_st_t st_nxt;
  verdict_t  verdict_nxt;

  logic out_free;
  logic s1_move;
  logic in_take;

  assign out_free  = !out_v_r || out_tready;
  assign s1_move   = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  fcr_step u_step (
    .cur_st     (st_r),
    .first_char (s1_first_r),
    .char_code  (s1_char_r),
    .max_mant   (max_mant_r),
    .max_exp    (max_exp_r),
    .nxt_st     (st_nxt),
    .verdict    (verdict_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      st_r       <= PARSE_ST_RST;
      max_mant_r <= MAX_MANT_RST;
      max_exp_r  <= MAX_EXP_RST;
    end else begin
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_MANT: max_mant_r <= cfg_wdata[MANT_W-1:0];
          REG_MAX_EXP:  max_exp_r  <= cfg_wdata[EXP_W-1:0];
          default: ;  // unused indexes are dropped
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r  <= in_tdata;
      s1_first_r <= in_tuser;
    end
    if (s1_move) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_verdict_r};

endmodule

### hw/rtl/fcr_step.sv
// One parser step: character class, next parse state and verdict.
// Depends on fcr_pkg.
module fcr_step (
  input  fcr_pkg::parse_st_t        cur_st,
  input  logic                      first_char,
  input  logic [7:0]                char_code,
  input  logic [fcr_pkg::MANT_W-1:0] max_mant,
  input  logic [fcr_pkg::EXP_W-1:0]  max_exp,
  output fcr_pkg::parse_st_t        nxt_st,
  output fcr_pkg::verdict_t         verdict
);
  import fcr_pkg::*;

  typedef enum logic [2:0] {
    K_OTHER  = 3'd0,
    K_DIGIT  = 3'd1,
    K_DOT    = 3'd2,
    K_SIGN   = 3'd3,
    K_EXP    = 3'd4,
    K_SUFFIX = 3'd5
  } kind_t;

  function automatic kind_t char_kind(input logic [7:0] c);
    kind_t k;
    k = K_OTHER;
    if (c >= 8'h30 && c <= 8'h39) k = K_DIGIT;
    else if (c == 8'h2E) k = K_DOT;
    else if (c == 8'h2B || c == 8'h2D) k = K_SIGN;
    else if (c == 8'h65 || c == 8'h45) k = K_EXP;
    else if (c == 8'h66 || c == 8'h46 || c == 8'h6C || c == 8'h4C) k = K_SUFFIX;
    return k;
  endfunction

  parse_st_t base;
  kind_t     kind;
  phase_t    act_phase;
  logic      m_ok, e_ok, m_any;

  always_comb begin
    base      = first_char ? PARSE_ST_RST : cur_st;
    kind      = char_kind(char_code);
    m_ok      = base.mcount < max_mant;
    e_ok      = base.ecount < max_exp;
    m_any     = base.mcount != '0;
    // a start phase without a sign falls straight into the integer part
    act_phase = (base.phase == PH_START && kind != K_SIGN) ? PH_INT : base.phase;

    nxt_st       = base;
    nxt_st.phase = PH_ERROR;
    verdict      = V_ERROR;

    unique case (act_phase)
      PH_START: begin
        nxt_st.phase = PH_INT;
        verdict      = V_CONT;
      end
      PH_INT: begin
        if (kind == K_DIGIT && m_ok) begin
          nxt_st.phase  = PH_INT;
          nxt_st.mcount = base.mcount + 1'b1;
          verdict       = V_CONT;
        end else if (kind == K_DOT) begin
          nxt_st.phase = PH_FRAC;
          verdict      = m_any ? V_MATCH : V_CONT;
        end else if (kind == K_EXP && m_any) begin
          nxt_st.phase = PH_EXP;
          verdict      = V_CONT;
        end
      end
      PH_FRAC: begin
        if (kind == K_DIGIT && m_ok) begin
          nxt_st.phase  = PH_FRAC;
          nxt_st.mcount = base.mcount + 1'b1;
          verdict       = V_MATCH;
        end else if (kind == K_EXP && m_any) begin
          nxt_st.phase = PH_EXP;
          verdict      = V_CONT;
        end else if (kind == K_SUFFIX && m_any) begin
          nxt_st.phase = PH_SUFFIX;
          verdict      = V_MATCH;
        end
      end
      PH_EXP: begin
        if (kind == K_SIGN) begin
          nxt_st.phase = PH_EXPSIGN;
          verdict      = V_CONT;
        end else if (kind == K_DIGIT && e_ok) begin
          nxt_st.phase  = PH_EXPDIG;
          nxt_st.ecount = base.ecount + 1'b1;
          verdict       = V_MATCH;
        end
      end
      PH_EXPSIGN, PH_EXPDIG: begin
        if (kind == K_DIGIT && e_ok) begin
          nxt_st.phase  = PH_EXPDIG;
          nxt_st.ecount = base.ecount + 1'b1;
          verdict       = V_MATCH;
        end else if (kind == K_SUFFIX && act_phase == PH_EXPDIG) begin
          nxt_st.phase = PH_SUFFIX;
          verdict      = V_MATCH;
        end
      end
      default: begin
        // after a suffix or in error: stays in error
        nxt_st.phase = PH_ERROR;
        verdict      = V_ERROR;
      end
    endcase
  end

endmodule

### hw/rtl/fcr_checker.sv
// Port-level checks for the float constant recognizer, bound to the top level.
// Depends on float_constant_recognizer_unit_assert.svh.
module fcr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
`include "float_constant_recognizer_unit_assert.svh"

  `FCR_ASSERT_ALWAYS(a_rst_clears, !rst_n, !out_tvalid, "result valid right after reset")
  `FCR_ASSERT_NOW(a_no_bad_code, out_tvalid, out_tdata[1:0] != 2'd3, "undefined verdict code")
  `FCR_ASSERT_NOW(a_accept_reaches_out, in_tvalid && in_tready, ##2 out_tvalid, "request lost in pipeline")
  `FCR_ASSERT_NXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind float_constant_recognizer_unit fcr_checker u_fcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for float_constant_recognizer_unit: a directed table, then random
// character strings over several limit settings, each verdict checked against the table or a local parser.
// Depends on fcr_pkg and the recognizer RTL.
module tb_top;
  import fcr_pkg::*;

  localparam int     CLK_HALF        = 5;
  localparam int     RST_CYCLES      = 9;
  localparam int     ITEMS_PER_PHASE = 240;
  // receiver hold-off: starts once this many verdicts are in, lasts this long
  localparam int     HOLD_AT         = 100;
  localparam int     HOLD_CYCLES     = 120;
  // settle margin before register writes and at the end
  localparam int     DRAIN_CYCLES    = 8;
  localparam longint CYCLE_LIMIT     = 400000;

  // indexes past the two limit registers; writes there must be ignored
  localparam logic [1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [1:0] REG_UNUSED_3 = 2'd3;

  typedef enum logic [2:0] {
    K_OTHER, K_DIGIT, K_DOT, K_SIGN, K_EXP, K_SUFFIX
  } char_kind_t;

  typedef struct {
    logic [7:0] code;
    logic       first;
  } char_req_t;

  // directed row: typed = 1 when the verdict is given here, else the parser decides
  typedef struct packed {
    logic [7:0] code;
    logic       first;
    logic       typed;
    verdict_t   want;
  } directed_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       cfg_we     = 1'b0;
  logic [1:0] cfg_index  = '0;
  logic [4:0] cfg_wdata  = '0;

  // local copy of the limits and the parse state
  logic [MANT_W-1:0] lim_mant = MAX_MANT_RST;
  logic [EXP_W-1:0]  lim_exp  = MAX_EXP_RST;
  phase_t            m_phase  = PH_START;
  logic [MANT_W-1:0] m_mcount = '0;
  logic [EXP_W-1:0]  m_ecount = '0;

  verdict_t  due_verdicts[$];   // verdicts owed by the block, oldest first
  char_req_t pending[$];        // characters built but not yet sent
  verdict_t  oldest;
  int        n_errors   = 0;
  int        n_verdicts = 0;
  int        hold_left  = 0;
  bit        hold_done  = 1'b0;
  bit        steady     = 1'b0; // no idling on either side while set
  longint    cycles     = 0;

  localparam logic [7:0] SUFFIXES [4] = '{"f", "F", "l", "L"};

  directed_row_t DIRECTED [25] = '{
    // leading dot, then a digit, a suffix, and a character after the suffix
    '{".", 1'b1, 1'b1, V_CONT},
    '{"5", 1'b0, 1'b1, V_MATCH},
    '{"f", 1'b0, 1'b1, V_MATCH},
    '{"1", 1'b0, 1'b1, V_ERROR},
    // every part of the grammar in one string: -1.5e+3F
    '{"-", 1'b1, 1'b0, V_CONT},
    '{"1", 1'b0, 1'b0, V_CONT},
    '{".", 1'b0, 1'b0, V_CONT},
    '{"5", 1'b0, 1'b0, V_CONT},
    '{"e", 1'b0, 1'b0, V_CONT},
    '{"+", 1'b0, 1'b0, V_CONT},
    '{"3", 1'b0, 1'b0, V_CONT},
    '{"F", 1'b0, 1'b0, V_CONT},
    // exponent with no mantissa; error sticks for the next digit
    '{"e", 1'b1, 1'b1, V_ERROR},
    '{"5", 1'b0, 1'b1, V_ERROR},
    // suffix right after 'e'
    '{"1", 1'b1, 1'b0, V_CONT},
    '{"e", 1'b0, 1'b0, V_CONT},
    '{"l", 1'b0, 1'b1, V_ERROR},
    // suffix right after the exponent sign
    '{"2", 1'b1, 1'b0, V_CONT},
    '{"E", 1'b0, 1'b0, V_CONT},
    '{"-", 1'b0, 1'b0, V_CONT},
    '{"L", 1'b0, 1'b1, V_ERROR},
    // byte outside the grammar, top code
    '{8'hFF, 1'b1, 1'b1, V_ERROR},
    // sign and dot with no digit, then a suffix
    '{"+", 1'b1, 1'b0, V_CONT},
    '{".", 1'b0, 1'b0, V_CONT},
    '{"f", 1'b0, 1'b1, V_ERROR}
  };

  float_constant_recognizer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] char_code
    .in_tuser   (in_tuser),    // [0] first_char
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [1:0] verdict, [7:2] zero
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake or a missing verdict ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%t: cycle limit reached, %0d verdicts still owed", $time, due_verdicts.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic char_kind_t char_kind(logic [7:0] c);
    if (c >= "0" && c <= "9") return K_DIGIT;
    if (c == ".") return K_DOT;
    if (c == "+" || c == "-") return K_SIGN;
    if (c == "e" || c == "E") return K_EXP;
    if (c == "f" || c == "F" || c == "l" || c == "L") return K_SUFFIX;
    return K_OTHER;
  endfunction

  // Digit over the limit poisons the string.
  function automatic verdict_t count_mant(verdict_t ok);
    if (m_mcount >= lim_mant) begin
      m_phase = PH_ERROR;
      return V_ERROR;
    end
    m_mcount = m_mcount + 1'b1;
    return ok;
  endfunction

  function automatic verdict_t count_exp();
    if (m_ecount >= lim_exp) begin
      m_phase = PH_ERROR;
      return V_ERROR;
    end
    m_ecount = m_ecount + 1'b1;
    return V_MATCH;
  endfunction

  function automatic verdict_t parse_char(logic [7:0] c, logic first);
    char_kind_t k;
    k = char_kind(c);
    if (first) begin
      m_phase  = PH_START;
      m_mcount = '0;
      m_ecount = '0;
    end
    // start phase only eats an optional sign, anything else is handled as integer part
    if (m_phase == PH_START) begin
      m_phase = PH_INT;
      if (k == K_SIGN) return V_CONT;
    end
    case (m_phase)
      PH_INT: begin
        if (k == K_DIGIT) return count_mant(V_CONT);
        if (k == K_DOT) begin
          m_phase = PH_FRAC;
          return (m_mcount != 0) ? V_MATCH : V_CONT;
        end
        if (k == K_EXP && m_mcount != 0) begin
          m_phase = PH_EXP;
          return V_CONT;
        end
      end
      PH_FRAC: begin
        if (k == K_DIGIT) return count_mant(V_MATCH);
        if (k == K_EXP && m_mcount != 0) begin
          m_phase = PH_EXP;
          return V_CONT;
        end
        if (k == K_SUFFIX && m_mcount != 0) begin
          m_phase = PH_SUFFIX;
          return V_MATCH;
        end
      end
      PH_EXP: begin
        if (k == K_SIGN) begin
          m_phase = PH_EXPSIGN;
          return V_CONT;
        end
        if (k == K_DIGIT) begin
          m_phase = PH_EXPDIG;
          return count_exp();
        end
      end
      PH_EXPSIGN: begin
        if (k == K_DIGIT) begin
          m_phase = PH_EXPDIG;
          return count_exp();
        end
      end
      PH_EXPDIG: begin
        if (k == K_DIGIT) return count_exp();
        if (k == K_SUFFIX) begin
          m_phase = PH_SUFFIX;
          return V_MATCH;
        end
      end
      default: ;
    endcase
    // suffix, error, or no legal move
    m_phase = PH_ERROR;
    return V_ERROR;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(1) ? "+" : "-";
  endfunction

  // Mostly well-formed constants with random lengths around the limits; some
  // get one byte clobbered, and some runs are plain noise with random first flags.
  function automatic void queue_string();
    logic [7:0] s[$];
    int r, total, ni, ne, lm, le;
    lm = (lim_mant == 0) ? 1 : int'(lim_mant);
    le = (lim_exp == 0) ? 1 : int'(lim_exp);
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4))
        pending.insert(pending.size(), '{code: 8'($urandom), first: 1'($urandom)});
      return;
    end
    if ($urandom_range(99) < 30) s.insert(s.size(), rand_sign());
    r = $urandom_range(99);
    total = (r < 5) ? 0 : (r < 15) ? int'(lim_mant) + 1 : int'($urandom_range(1, lm));
    ni = $urandom_range(0, total);
    repeat (ni) s.insert(s.size(), rand_digit());
    if (ni != total || $urandom_range(99) < 60) begin
      s.insert(s.size(), ".");
      repeat (total - ni) s.insert(s.size(), rand_digit());
    end
    if ($urandom_range(99) < 50) begin
      s.insert(s.size(), $urandom_range(1) ? "e" : "E");
      if ($urandom_range(99) < 40) s.insert(s.size(), rand_sign());
      r = $urandom_range(99);
      ne = (r < 5) ? 0 : (r < 15) ? int'(lim_exp) + 1 : int'($urandom_range(1, le));
      repeat (ne) s.insert(s.size(), rand_digit());
    end
    if ($urandom_range(99) < 40) s.insert(s.size(), SUFFIXES[$urandom_range(3)]);
    if (s.size() == 0) s.insert(s.size(), rand_digit());
    if ($urandom_range(99) < 10) s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
    foreach (s[i]) pending.insert(pending.size(), '{code: s[i], first: (i == 0)});
  endfunction

  // One input request; the owed verdict is queued at the accepting edge.
  task automatic send_char(input logic [7:0] code, input logic first,
                           input logic typed, input verdict_t want);
    verdict_t v;
    while (!steady && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = parse_char(code, first);
    due_verdicts.insert(due_verdicts.size(), typed ? want : v);
  endtask

  // Sender pause: wait out every owed verdict plus the pipeline.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (due_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_MAX_MANT) lim_mant = data;
    else if (idx == REG_MAX_EXP) lim_exp = data[EXP_W-1:0];
  endtask

  task automatic run_random(input int count);
    char_req_t c;
    int sent;
    sent = 0;
    // finish the string in flight so the phase ends on a clean boundary
    while (sent < count || pending.size() != 0) begin
      if (pending.size() == 0) queue_string();
      c = pending.pop_front();
      send_char(c.code, c.first, 1'b0, V_CONT);
      sent++;
    end
  endtask

  // New limits while idle, plus a write to an index past the register file.
  task automatic run_phase(input logic [4:0] mant, input logic [4:0] expw, input bit quiet);
    drain();
    write_reg(REG_MAX_MANT, mant);
    write_reg(REG_MAX_EXP, expw);
    write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, 5'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    steady = quiet;
    run_random(ITEMS_PER_PHASE);
    steady = 1'b0;
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: 16 mantissa, 3 exponent digits
    foreach (DIRECTED[i])
      send_char(DIRECTED[i].code, DIRECTED[i].first, DIRECTED[i].typed, DIRECTED[i].want);
    run_random(ITEMS_PER_PHASE);   // receiver hold-off lands in here

    run_phase(5'd1, 5'd1, 1'b0);         // tightest legal limits
    run_phase(5'd31, 5'd7, 1'b0);        // widest limits
    run_phase(5'd0, 5'd0, 1'b0);         // zero limits: every digit is an error
    run_phase(5'd5, 5'b11010, 1'b0);     // exponent upper bits dropped, limit 2
    run_phase(5'($urandom_range(1, 31)), 5'($urandom), 1'b1); // back-to-back traffic

    drain();
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: check each accepted verdict, drive out_tready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_verdicts.size() == 0) begin
        $display("%t: verdict with no request pending: expected none, got %h",
                 $time, out_tdata);
        n_errors++;
      end else begin
        oldest = due_verdicts.pop_front();
        if (out_tdata !== {6'b0, oldest}) begin
          $display("%t: verdict mismatch: expected %h, got %h",
                   $time, {6'b0, oldest}, out_tdata);
          n_errors++;
        end
      end
      n_verdicts++;
    end
    // one long hold-off while the sender keeps pushing, so the input side stalls
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && n_verdicts >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (steady || $urandom_range(99) >= 16);
    end
  end

endmodule
